[src/salc_pkg.sv]
// Shared types and constants for the set-associative LRU cache model.
// Used by salc_addr_split, salc_way_scan and the top module; depends on nothing else.
package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;
  localparam int MAX_OFFSET   = 32;

  localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS   = 1 << MAX_SET_BITS;
  localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W      = WAY_W;
  localparam int CNT_W      = $clog2(MAX_WAYS + 1);
  localparam int TAG_ADDR_W = SET_W + WAY_W;
  localparam int TAG_DEPTH  = NUM_SETS << WAY_W;
  localparam int SHIFT_W    = $clog2(MAX_SET_BITS + MAX_OFFSET + 1);

  // Configuration register widths and indexes.
  localparam int SETB_W = 3;
  localparam int WAYS_W = 4;
  localparam int OFFB_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

  localparam logic [SETB_W-1:0] SETB_RESET = 3'd4;
  localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd1;
  localparam logic [OFFB_W-1:0] OFFB_RESET = 6'd4;

  // Access kinds and result outcomes.
  localparam logic CMD_STORE = 1'b1;
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // Per-set bookkeeping row: valid, dirty and recency rank of each way.
  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0]            dirty;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [WAY_W-1:0] way;
  } scan_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             old_found;
    logic [WAY_W-1:0] old_way;
    logic             free_found;
    logic [WAY_W-1:0] free_way;
    logic [CNT_W-1:0] count;
  } scan_res_t;

endpackage

[src/salc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the tag store and the per-set bookkeeping store.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/salc_addr_split.sv]
// Splits an access address into set index and tag under the current configuration.
// Depends on salc_pkg.
module salc_addr_split (
  input  logic [salc_pkg::ADDR_WIDTH-1:0] address,
  input  logic [salc_pkg::SETB_W-1:0]     set_bits,
  input  logic [salc_pkg::OFFB_W-1:0]     offset_bits,
  output logic [salc_pkg::SET_W-1:0]      set_index,
  output logic [salc_pkg::ADDR_WIDTH-1:0] tag
);

  logic [salc_pkg::SHIFT_W-1:0]    sb;
  logic [salc_pkg::SHIFT_W-1:0]    ob;
  logic [salc_pkg::ADDR_WIDTH-1:0] shifted;
  logic [salc_pkg::SET_W-1:0]      mask;

  always_comb begin
    // Out-of-range settings clamp to the largest supported value.
    sb = (salc_pkg::SHIFT_W'(set_bits) > salc_pkg::SHIFT_W'(salc_pkg::MAX_SET_BITS)) ?
         salc_pkg::SHIFT_W'(salc_pkg::MAX_SET_BITS) : salc_pkg::SHIFT_W'(set_bits);
    ob = (salc_pkg::SHIFT_W'(offset_bits) > salc_pkg::SHIFT_W'(salc_pkg::MAX_OFFSET)) ?
         salc_pkg::SHIFT_W'(salc_pkg::MAX_OFFSET) : salc_pkg::SHIFT_W'(offset_bits);
    for (int i = 0; i < salc_pkg::SET_W; i++) begin
      mask[i] = (salc_pkg::SHIFT_W'(i) < sb);
    end
    shifted   = address >> ob;
    set_index = shifted[salc_pkg::SET_W-1:0] & mask;
    tag       = address >> (sb + ob);
  end

endmodule

[src/salc_way_scan.sv]
// Shared tag comparator that walks the ways of one set, one way per step cycle.
// Tracks the first hit, the oldest valid way, the first free way and the fill count.
// Depends on salc_pkg.
module salc_way_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  salc_pkg::scan_ctl_t             ctl,
  input  logic                            way_valid,
  input  logic [salc_pkg::AGE_W-1:0]      way_age,
  input  logic [salc_pkg::ADDR_WIDTH-1:0] stored_tag,
  input  logic [salc_pkg::ADDR_WIDTH-1:0] lookup_tag,
  output salc_pkg::scan_res_t             res
);

  logic [salc_pkg::AGE_W-1:0] old_age;
  logic                       tag_eq;

  assign tag_eq = (stored_tag == lookup_tag);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      res     <= '0;
      old_age <= '0;
    end else if (ctl.step) begin
      if (way_valid) begin
        res.count <= res.count + 1'b1;
        if (!res.hit && tag_eq) begin
          res.hit     <= 1'b1;
          res.hit_way <= ctl.way;
        end
        // Strictly greater keeps the lowest way among equal ranks.
        if (!res.old_found || way_age > old_age) begin
          res.old_found <= 1'b1;
          res.old_way   <= ctl.way;
          old_age       <= way_age;
        end
      end else if (!res.free_found) begin
        res.free_found <= 1'b1;
        res.free_way   <= ctl.way;
      end
    end
  end

endmodule

[src/set_assoc_lru_cache_model.sv]
// Set-associative write-back cache model with LRU replacement and hit/miss/eviction totals.
// An access runs the split, meta, scan and update states (update waits on the output); the
// next waits for idle. The shared tag comparator checks one way per cycle (8 ways).
// Reset clears the totals, loads the configuration defaults and clears 64 per-set valid
// flags at once; no clearing pass runs, so the block is ready right after reset.
// Depends on salc_pkg, salc_ram, salc_addr_split and salc_way_scan.
module set_assoc_lru_cache_model (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
  // Access stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [71:0]                    s_tdata,  // [0] command, [64:1] address, rest zero
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] outcome, [2] victim_dirty, [34:3] hit_total, [66:35] miss_total,
  // [98:67] eviction_total, rest zero
  output logic [103:0]                   m_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPLIT  = 3'd1;
  localparam logic [2:0] ST_META   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  logic [2:0] state;

  logic [salc_pkg::SETB_W-1:0] set_bits;
  logic [salc_pkg::WAYS_W-1:0] ways_in_use;
  logic [salc_pkg::OFFB_W-1:0] offset_bits;

  logic                            cmd_r;
  logic [salc_pkg::ADDR_WIDTH-1:0] addr_r;
  logic [salc_pkg::SET_W-1:0]      idx_r;
  logic [salc_pkg::ADDR_WIDTH-1:0] tag_r;
  salc_pkg::meta_t                 meta_r;
  logic [salc_pkg::WAY_W-1:0]      scan_way;
  logic [salc_pkg::NUM_SETS-1:0]   row_valid;

  logic [1:0]  outcome;
  logic        victim_dirty;
  logic [31:0] hits_seen;
  logic [31:0] misses_seen;
  logic [31:0] evictions_seen;

  logic [salc_pkg::SET_W-1:0]      split_idx;
  logic [salc_pkg::ADDR_WIDTH-1:0] split_tag;
  logic [salc_pkg::META_W-1:0]     meta_rdata;
  logic [salc_pkg::ADDR_WIDTH-1:0] tag_rdata;
  logic [salc_pkg::TAG_ADDR_W-1:0] tag_raddr;
  salc_pkg::scan_ctl_t             scan_ctl;
  salc_pkg::scan_res_t             scan_res;

  logic                       upd_fire;
  logic                       evict;
  logic                       age_all;
  logic [salc_pkg::AGE_W-1:0] age_limit;
  logic [salc_pkg::WAY_W-1:0] fill_way;
  logic [salc_pkg::CNT_W-1:0] wl_eff;
  salc_pkg::meta_t            meta_next;
  logic [1:0]                 outcome_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign m_tdata   = {5'b0, evictions_seen, misses_seen, hits_seen, victim_dirty, outcome};

  salc_addr_split u_split (
    .address     (addr_r),
    .set_bits    (set_bits),
    .offset_bits (offset_bits),
    .set_index   (split_idx),
    .tag         (split_tag)
  );

  salc_ram #(
    .WIDTH (salc_pkg::META_W),
    .DEPTH (salc_pkg::NUM_SETS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (upd_fire),
    .waddr (idx_r),
    .wdata (meta_next),
    .raddr (split_idx),
    .rdata (meta_rdata)
  );

  // Way 0 is fetched while the row is latched; each scan cycle fetches the next way.
  assign tag_raddr = (state == ST_META) ? {idx_r, salc_pkg::WAY_W'(0)} :
                                          {idx_r, salc_pkg::WAY_W'(scan_way + 1'b1)};

  salc_ram #(
    .WIDTH (salc_pkg::ADDR_WIDTH),
    .DEPTH (salc_pkg::TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (upd_fire && !scan_res.hit),
    .waddr ({idx_r, fill_way}),
    .wdata (tag_r),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  assign scan_ctl.clear = (state == ST_META);
  assign scan_ctl.step  = (state == ST_SCAN);
  assign scan_ctl.way   = scan_way;

  salc_way_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .way_valid  (meta_r.valid[scan_way]),
    .way_age    (meta_r.age[scan_way]),
    .stored_tag (tag_rdata),
    .lookup_tag (tag_r),
    .res        (scan_res)
  );

  always_comb begin
    if (ways_in_use == '0) begin
      wl_eff = salc_pkg::CNT_W'(1);
    end else if (32'(ways_in_use) > salc_pkg::MAX_WAYS) begin
      wl_eff = salc_pkg::CNT_W'(salc_pkg::MAX_WAYS);
    end else begin
      wl_eff = salc_pkg::CNT_W'(ways_in_use);
    end

    upd_fire = (state == ST_UPDATE) && (!m_tvalid || m_tready);
    evict    = !scan_res.hit && scan_res.old_found && (scan_res.count >= wl_eff);
    fill_way = evict ? scan_res.old_way :
               (scan_res.free_found ? scan_res.free_way : '0);
    // A fill into a free way ages every valid line; otherwise only those younger
    // than the line that is touched or replaced.
    age_all   = !scan_res.hit && !evict;
    age_limit = scan_res.hit ? meta_r.age[scan_res.hit_way] : meta_r.age[scan_res.old_way];

    meta_next = meta_r;
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      if (meta_r.valid[w] && (age_all || meta_r.age[w] < age_limit)) begin
        meta_next.age[w] = meta_r.age[w] + 1'b1;
      end
    end
    if (scan_res.hit) begin
      meta_next.age[scan_res.hit_way] = '0;
      if (cmd_r == salc_pkg::CMD_STORE) begin
        meta_next.dirty[scan_res.hit_way] = 1'b1;
      end
    end else begin
      meta_next.valid[fill_way] = 1'b1;
      meta_next.age[fill_way]   = '0;
      meta_next.dirty[fill_way] = (cmd_r == salc_pkg::CMD_STORE);
    end

    outcome_next = scan_res.hit ? salc_pkg::OUT_HIT :
                   (evict ? salc_pkg::OUT_EVICT : salc_pkg::OUT_MISS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      row_valid      <= '0;
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
      set_bits       <= salc_pkg::SETB_RESET;
      ways_in_use    <= salc_pkg::WAYS_RESET;
      offset_bits    <= salc_pkg::OFFB_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          salc_pkg::CFG_SET_BITS:    set_bits    <= cfg_data[salc_pkg::SETB_W-1:0];
          salc_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data[salc_pkg::WAYS_W-1:0];
          salc_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data[salc_pkg::OFFB_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_r  <= s_tdata[0];
            addr_r <= s_tdata[salc_pkg::ADDR_WIDTH:1];
            state  <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          idx_r <= split_idx;
          tag_r <= split_tag;
          state <= ST_META;
        end
        ST_META: begin
          // A set never written reads as empty.
          meta_r   <= row_valid[idx_r] ? salc_pkg::meta_t'(meta_rdata) : '0;
          scan_way <= '0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_way <= scan_way + 1'b1;
          if (scan_way == salc_pkg::WAY_W'(salc_pkg::MAX_WAYS - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (upd_fire) begin
            row_valid[idx_r] <= 1'b1;
            outcome          <= outcome_next;
            victim_dirty     <= evict && meta_r.dirty[scan_res.old_way];
            m_tvalid         <= 1'b1;
            if (scan_res.hit) begin
              hits_seen <= (hits_seen == '1) ? hits_seen : hits_seen + 1'b1;
            end else begin
              misses_seen <= (misses_seen == '1) ? misses_seen : misses_seen + 1'b1;
            end
            if (evict) begin
              evictions_seen <= (evictions_seen == '1) ? evictions_seen :
                                evictions_seen + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an access is still in progress");

  a_victim_only_on_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!victim_dirty || outcome == salc_pkg::OUT_EVICT))
    else $error("dirty victim reported without an eviction");

  a_outcome_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (outcome == salc_pkg::OUT_HIT || outcome == salc_pkg::OUT_MISS ||
                  outcome == salc_pkg::OUT_EVICT))
    else $error("result carries an undefined outcome");

  a_evictions_bounded: assert property (@(posedge clk) disable iff (rst)
    evictions_seen <= misses_seen)
    else $error("more evictions than misses");
`endif

endmodule
